/* src/rti_pkg.sv */
// rti_pkg: shared constants and register codes for the ray/triangle intersection block
// no dependencies; used by rti_isect_if, by ray_triangle_intersect and by the testbench
package rti_pkg;

	localparam int DIST_W    = 32;  // distance width, unsigned Q16.16
	localparam int DIST_FRAC = 16;
	localparam int REG_W     = 63;  // configuration register width
	localparam int APB_DW    = 64;
	localparam int APB_AW    = 5;   // four registers at an 8 byte stride

	typedef enum logic [1:0] {
		REG_VERTEX_A    = 2'd0,
		REG_VERTEX_B    = 2'd1,
		REG_VERTEX_C    = 2'd2,
		REG_UNIT_NORMAL = 2'd3
	} reg_idx_t;

endpackage

/* src/rti_ray_if.sv */
// rti_ray_if: valid/ready channel carrying one ray (origin and direction)
// depends on nothing; coordinate width set by parameter
interface rti_ray_if #(parameter int COORD_WIDTH = 21);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] origin_x;
	logic signed [COORD_WIDTH-1:0] origin_y;
	logic signed [COORD_WIDTH-1:0] origin_z;
	logic signed [COORD_WIDTH-1:0] dir_x;
	logic signed [COORD_WIDTH-1:0] dir_y;
	logic signed [COORD_WIDTH-1:0] dir_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

/* src/rti_isect_if.sv */
// rti_isect_if: valid/ready channel carrying one intersection result
// depends on rti_pkg for the distance width
interface rti_isect_if import rti_pkg::*; #(parameter int COORD_WIDTH = 21);
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [DIST_W-1:0]             distance;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;
	logic signed [COORD_WIDTH-1:0] norm_x;
	logic signed [COORD_WIDTH-1:0] norm_y;
	logic signed [COORD_WIDTH-1:0] norm_z;

	modport source (output valid, hit, distance, point_x, point_y, point_z,
		norm_x, norm_y, norm_z, input ready);
	modport sink (input valid, hit, distance, point_x, point_y, point_z,
		norm_x, norm_y, norm_z, output ready);
endinterface

/* src/ray_triangle_intersect.sv */
// ray_triangle_intersect: pipelined ray/triangle test, plane distance then barycentric check
// depends on rti_pkg, rti_ray_if, rti_isect_if
//
//   channel  | kind        | payload
//   ---------+-------------+----------------------------------------------
//   ray      | sink        | origin_x/y/z, dir_x/y/z
//   isect    | source      | hit, distance, point_x/y/z, norm_x/y/z
//   apb      | config port | vertex_a, vertex_b, vertex_c, unit_normal
//
// one ray enters per cycle while the pipe is not stalled; the pipe is the 32 stage restoring
// divider for t plus eleven arithmetic stages (wide gram products are split in halves)
// the whole pipe advances together; it holds only when the output register is full
// and the sink is not ready, so a stall drops and repeats nothing
// reset clears the valid bits and the configuration registers
module ray_triangle_intersect import rti_pkg::*; #(
	parameter int COORD_WIDTH = 21
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	rti_ray_if.sink           ray,
	rti_isect_if.source       isect
);

	localparam int CW   = COORD_WIDTH;
	localparam int EW   = CW + 1;          // vertex differences
	localparam int PW   = 2 * CW + 1;      // plane products
	localparam int NW   = 2 * CW + 3;      // plane dot products
	localparam int RW   = NW + DIST_W;     // divider remainder
	localparam int NDIV = DIST_W;
	localparam int MW   = CW + DIST_W + 1; // t * dir
	localparam int XW   = MW + 1;
	localparam int GPW  = 2 * EW;          // gram products
	localparam int GW   = 2 * EW + 2;      // gram entries
	localparam int LW   = GW / 2;          // low half of a split operand
	localparam int HW   = GW - LW;
	localparam int PPW  = GW + 2;          // partial products
	localparam int FW   = 2 * GW + 2;      // det and numerators
	localparam logic signed [XW-1:0] RND_HALF = XW'(1) << (DIST_FRAC - 1);
	localparam int OPA [6] = '{0, 1, 2, 1, 0, 1};
	localparam int OPB [6] = '{2, 1, 3, 4, 4, 3};

	// configuration registers
	logic [REG_W-1:0] va_q, vb_q, vc_q, vn_q;
	logic             cfg_wr;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= '0;
			vb_q <= '0;
			vc_q <= '0;
			vn_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[APB_AW-1:3]))
				REG_VERTEX_A:    va_q <= pwdata[REG_W-1:0];
				REG_VERTEX_B:    vb_q <= pwdata[REG_W-1:0];
				REG_VERTEX_C:    vc_q <= pwdata[REG_W-1:0];
				REG_UNIT_NORMAL: vn_q <= pwdata[REG_W-1:0];
				default:         va_q <= va_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[APB_AW-1:3]))
			REG_VERTEX_A:    prdata = {1'b0, va_q};
			REG_VERTEX_B:    prdata = {1'b0, vb_q};
			REG_VERTEX_C:    prdata = {1'b0, vc_q};
			REG_UNIT_NORMAL: prdata = {1'b0, vn_q};
			default:         prdata = '0;
		endcase
	end

	logic signed [CW-1:0] a_c [3], b_c [3], c_c [3], n_c [3];
	logic signed [EW-1:0] ab [3], ac [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a_c[k] = va_q[k*CW +: CW];
			b_c[k] = vb_q[k*CW +: CW];
			c_c[k] = vc_q[k*CW +: CW];
			n_c[k] = vn_q[k*CW +: CW];
			ab[k]  = EW'(b_c[k]) - EW'(a_c[k]);
			ac[k]  = EW'(c_c[k]) - EW'(a_c[k]);
		end
	end

	// pipe advance
	logic en;
	logic v_s1, v_s2, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic [NDIV-1:0] dv_v_s3;

	assign en        = !v_s12 || isect.ready;
	assign ray.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			dv_v_s3 <= '0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			v_s8    <= 1'b0;
			v_s9    <= 1'b0;
			v_s10   <= 1'b0;
			v_s11   <= 1'b0;
			v_s12   <= 1'b0;
		end else if (en) begin
			v_s1    <= ray.valid;
			v_s2    <= v_s1;
			dv_v_s3 <= {dv_v_s3[NDIV-2:0], v_s2};
			v_s4    <= dv_v_s3[NDIV-1];
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			v_s7    <= v_s6;
			v_s8    <= v_s7;
			v_s9    <= v_s8;
			v_s10   <= v_s9;
			v_s11   <= v_s10;
			v_s12   <= v_s11;
		end
	end

	// stage 1: plane products (a - o).n and d.n
	logic signed [CW-1:0] o_in [3], d_in [3];
	logic signed [EW-1:0] ao [3];
	logic signed [PW-1:0] pn [3], pd [3];
	logic signed [CW-1:0] o_s1 [3], d_s1 [3];
	logic signed [PW-1:0] pn_s1 [3], pd_s1 [3];

	always_comb begin
		o_in[0] = ray.origin_x;
		o_in[1] = ray.origin_y;
		o_in[2] = ray.origin_z;
		d_in[0] = ray.dir_x;
		d_in[1] = ray.dir_y;
		d_in[2] = ray.dir_z;
		for (int k = 0; k < 3; k++) begin
			ao[k] = EW'(a_c[k]) - EW'(o_in[k]);
			pn[k] = PW'(ao[k]) * PW'(n_c[k]);
			pd[k] = PW'(d_in[k]) * PW'(n_c[k]);
		end
	end

	// stage 2: sums, sign fold so the denominator is positive
	logic signed [NW-1:0] num, den, num_adj, den_adj;
	logic                 miss_pl;
	logic signed [CW-1:0] o_s2 [3], d_s2 [3];
	logic [NW-1:0]        num_m_s2, den_m_s2;
	logic                 miss_s2;

	always_comb begin
		num     = NW'(pn_s1[0]) + NW'(pn_s1[1]) + NW'(pn_s1[2]);
		den     = NW'(pd_s1[0]) + NW'(pd_s1[1]) + NW'(pd_s1[2]);
		num_adj = den[NW-1] ? -num : num;
		den_adj = den[NW-1] ? -den : den;
		// parallel ray or hit behind the origin
		miss_pl = (den == '0) || num_adj[NW-1];
	end

	// stage 3: restoring divider, one quotient bit per stage
	logic [RW-1:0]        dv_rem_s3 [NDIV];
	logic [NW-1:0]        dv_den_s3 [NDIV];
	logic [DIST_W-1:0]    dv_q_s3 [NDIV];
	logic                 dv_miss_s3 [NDIV];
	logic signed [CW-1:0] dv_o_s3 [NDIV][3];
	logic signed [CW-1:0] dv_d_s3 [NDIV][3];

	for (genvar j = 0; j < NDIV; j++) begin : g_div
		localparam int SH = NDIV - 1 - j;
		logic [RW-1:0]        rem_i, trial;
		logic [NW-1:0]        den_i;
		logic [DIST_W-1:0]    q_i;
		logic                 miss_i;
		logic signed [CW-1:0] o_i [3], d_i [3];

		if (j == 0) begin : g_first
			always_comb begin
				rem_i  = RW'(num_m_s2) << DIST_FRAC;
				den_i  = den_m_s2;
				q_i    = '0;
				// t would not fit in the distance field
				miss_i = miss_s2 || (RW'(num_m_s2) >= (RW'(den_m_s2) << DIST_FRAC));
				o_i    = o_s2;
				d_i    = d_s2;
			end
		end else begin : g_next
			always_comb begin
				rem_i  = dv_rem_s3[j-1];
				den_i  = dv_den_s3[j-1];
				q_i    = dv_q_s3[j-1];
				miss_i = dv_miss_s3[j-1];
				o_i    = dv_o_s3[j-1];
				d_i    = dv_d_s3[j-1];
			end
		end

		assign trial = RW'(den_i) << SH;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_i >= trial) begin
					dv_rem_s3[j] <= rem_i - trial;
					dv_q_s3[j]   <= q_i | (DIST_W'(1) << SH);
				end else begin
					dv_rem_s3[j] <= rem_i;
					dv_q_s3[j]   <= q_i;
				end
				dv_den_s3[j]  <= den_i;
				dv_miss_s3[j] <= miss_i;
				dv_o_s3[j]    <= o_i;
				dv_d_s3[j]    <= d_i;
			end
		end
	end

	// stage 4: t * d
	logic [DIST_W-1:0]    tq;
	logic signed [MW-1:0] td [3];

	assign tq = dv_q_s3[NDIV-1];

	always_comb begin
		for (int k = 0; k < 3; k++)
			td[k] = MW'($signed({1'b0, tq})) * MW'(dv_d_s3[NDIV-1][k]);
	end

	logic signed [CW-1:0] o_s4 [3];
	logic signed [MW-1:0] td_s4 [3];
	logic [DIST_W-1:0]    tq_s4;
	logic                 miss_s4;

	// stage 5: round half up, add origin, range check
	logic signed [XW-1:0] rs [3], pw [3];
	logic                 oor;

	always_comb begin
		oor = 1'b0;
		for (int k = 0; k < 3; k++) begin
			rs[k] = XW'(td_s4[k]) + RND_HALF;
			pw[k] = XW'(o_s4[k]) + (rs[k] >>> DIST_FRAC);
			if (pw[k] != XW'($signed(pw[k][CW-1:0])))
				oor = 1'b1;
		end
	end

	logic signed [CW-1:0] p_s5 [3];
	logic [DIST_W-1:0]    tq_s5;
	logic                 miss_s5;

	// stage 6: gram products
	logic signed [EW-1:0]  ap [3];
	logic signed [GPW-1:0] gp [5][3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ap[k]    = EW'(p_s5[k]) - EW'(a_c[k]);
			gp[0][k] = GPW'(ab[k]) * GPW'(ab[k]);
			gp[1][k] = GPW'(ab[k]) * GPW'(ac[k]);
			gp[2][k] = GPW'(ac[k]) * GPW'(ac[k]);
			gp[3][k] = GPW'(ab[k]) * GPW'(ap[k]);
			gp[4][k] = GPW'(ac[k]) * GPW'(ap[k]);
		end
	end

	logic signed [GPW-1:0] gp_s6 [5][3];
	logic signed [CW-1:0]  p_s6 [3];
	logic [DIST_W-1:0]     tq_s6;
	logic                  miss_s6;

	// stage 7: gram entries d00 d01 d11 d02 d12
	logic signed [GW-1:0] g_s7 [5];
	logic signed [CW-1:0] p_s7 [3];
	logic [DIST_W-1:0]    tq_s7;
	logic                 miss_s7;

	// stage 8: split products, operands cut in high and low halves
	logic signed [HW-1:0]  xh, yh;
	logic [LW-1:0]         xl, yl;
	logic signed [PPW-1:0] hh [6], hl [6], lh [6], ll [6];

	always_comb begin
		for (int m = 0; m < 6; m++) begin
			xh    = g_s7[OPA[m]][GW-1:LW];
			xl    = g_s7[OPA[m]][LW-1:0];
			yh    = g_s7[OPB[m]][GW-1:LW];
			yl    = g_s7[OPB[m]][LW-1:0];
			hh[m] = PPW'(xh) * PPW'(yh);
			hl[m] = PPW'(xh) * PPW'($signed({1'b0, yl}));
			lh[m] = PPW'($signed({1'b0, xl})) * PPW'(yh);
			ll[m] = PPW'($signed({1'b0, xl})) * PPW'($signed({1'b0, yl}));
		end
	end

	logic signed [PPW-1:0] hh_s8 [6], hl_s8 [6], lh_s8 [6], ll_s8 [6];
	logic signed [CW-1:0]  p_s8 [3];
	logic [DIST_W-1:0]     tq_s8;
	logic                  miss_s8;

	// stage 9: recombine the six products
	logic signed [FW-1:0] prd [6];

	always_comb begin
		for (int m = 0; m < 6; m++)
			prd[m] = (FW'(hh_s8[m]) <<< (2 * LW))
				+ ((FW'(hl_s8[m]) + FW'(lh_s8[m])) <<< LW) + FW'(ll_s8[m]);
	end

	logic signed [FW-1:0] prd_s9 [6];
	logic signed [CW-1:0] p_s9 [3];
	logic [DIST_W-1:0]    tq_s9;
	logic                 miss_s9;

	// stage 10: det, un, vn
	logic signed [FW-1:0] det_s10, un_s10, vn_s10;
	logic signed [CW-1:0] p_s10 [3];
	logic [DIST_W-1:0]    tq_s10;
	logic                 miss_s10;

	// stage 11: sign tests, un + vn
	logic                 miss_bc;
	logic signed [FW-1:0] det_s11, uv_s11;
	logic signed [CW-1:0] p_s11 [3];
	logic [DIST_W-1:0]    tq_s11;
	logic                 miss_s11;

	// degenerate triangle or point outside the edges
	assign miss_bc = det_s10[FW-1] || (det_s10 == '0) || un_s10[FW-1] || vn_s10[FW-1];

	// stage 12: u + v <= 1, output register
	logic signed [FW-1:0] slack;
	logic                 miss_fin;

	assign slack    = det_s11 - uv_s11;
	assign miss_fin = miss_s11 || slack[FW-1];

	logic                 hit_s12;
	logic [DIST_W-1:0]    dist_s12;
	logic signed [CW-1:0] p_s12 [3], n_s12 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			o_s1  <= o_in;
			d_s1  <= d_in;
			pn_s1 <= pn;
			pd_s1 <= pd;

			o_s2     <= o_s1;
			d_s2     <= d_s1;
			num_m_s2 <= num_adj;
			den_m_s2 <= den_adj;
			miss_s2  <= miss_pl;

			o_s4    <= dv_o_s3[NDIV-1];
			td_s4   <= td;
			tq_s4   <= tq;
			miss_s4 <= dv_miss_s3[NDIV-1];

			for (int k = 0; k < 3; k++)
				p_s5[k] <= pw[k][CW-1:0];
			tq_s5   <= tq_s4;
			miss_s5 <= miss_s4 || oor;

			gp_s6   <= gp;
			p_s6    <= p_s5;
			tq_s6   <= tq_s5;
			miss_s6 <= miss_s5;

			for (int g = 0; g < 5; g++)
				g_s7[g] <= GW'(gp_s6[g][0]) + GW'(gp_s6[g][1]) + GW'(gp_s6[g][2]);
			p_s7    <= p_s6;
			tq_s7   <= tq_s6;
			miss_s7 <= miss_s6;

			hh_s8   <= hh;
			hl_s8   <= hl;
			lh_s8   <= lh;
			ll_s8   <= ll;
			p_s8    <= p_s7;
			tq_s8   <= tq_s7;
			miss_s8 <= miss_s7;

			prd_s9  <= prd;
			p_s9    <= p_s8;
			tq_s9   <= tq_s8;
			miss_s9 <= miss_s8;

			det_s10  <= prd_s9[0] - prd_s9[1];
			un_s10   <= prd_s9[2] - prd_s9[3];
			vn_s10   <= prd_s9[4] - prd_s9[5];
			p_s10    <= p_s9;
			tq_s10   <= tq_s9;
			miss_s10 <= miss_s9;

			det_s11  <= det_s10;
			uv_s11   <= un_s10 + vn_s10;
			p_s11    <= p_s10;
			tq_s11   <= tq_s10;
			miss_s11 <= miss_s10 || miss_bc;

			// a miss zeroes every field
			hit_s12  <= !miss_fin;
			dist_s12 <= miss_fin ? '0 : tq_s11;
			for (int k = 0; k < 3; k++) begin
				p_s12[k] <= miss_fin ? '0 : p_s11[k];
				n_s12[k] <= miss_fin ? '0 : n_c[k];
			end
		end
	end

	assign isect.valid    = v_s12;
	assign isect.hit      = hit_s12;
	assign isect.distance = dist_s12;
	assign isect.point_x  = p_s12[0];
	assign isect.point_y  = p_s12[1];
	assign isect.point_z  = p_s12[2];
	assign isect.norm_x   = n_s12[0];
	assign isect.norm_y   = n_s12[1];
	assign isect.norm_z   = n_s12[2];

endmodule

/* tb/sv/tb_ray_triangle_intersect.sv */
// tb_ray_triangle_intersect: self-checking bench for ray_triangle_intersect
// depends on rti_pkg, rti_ray_if, rti_isect_if; rays are predicted in-bench and
// compared transfer by transfer against the isect channel
`timescale 1ns / 100ps

module tb_ray_triangle_intersect import rti_pkg::*;;

	localparam int CW = 21;
	localparam int LIMIT_CYCLES = 400000;
	localparam int RAYS_PER_PHASE = 205;
	localparam int NUM_PHASES = 9;

	typedef struct {
		logic signed [CW-1:0] org [3];
		logic signed [CW-1:0] dir [3];
	} ray_t;

	typedef struct packed {
		logic                 hit;
		logic [DIST_W-1:0]    distance;
		logic signed [CW-1:0] px, py, pz, nx, ny, nz;
	} isect_t;

	typedef struct {
		ray_t   ray;
		bit     known;
		isect_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	rti_ray_if   #(.COORD_WIDTH(CW)) ray_ch ();
	rti_isect_if #(.COORD_WIDTH(CW)) isect_ch ();

	ray_triangle_intersect #(.COORD_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.ray(ray_ch), .isect(isect_ch)
	);

	// shadow copy of the triangle registers
	logic [REG_W-1:0] tri_regs [4] = '{default: '0};
	isect_t pending_hits [$];
	int mismatches = 0;
	int cycles = 0;
	int burst_left = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		ray_ch.valid = 1'b0;
		ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.origin_z = '0;
		ray_ch.dir_x = '0; ray_ch.dir_y = '0; ray_ch.dir_z = '0;
		isect_ch.ready = 1'b0;
	end

	function automatic longint coord(logic [REG_W-1:0] r, int k);
		logic signed [CW-1:0] f;
		f = r[k*CW +: CW];
		return f;
	endfunction

	function automatic longint dot3(longint x [3], longint y [3]);
		return x[0]*y[0] + x[1]*y[1] + x[2]*y[2];
	endfunction

	function automatic isect_t intersect_ray(ray_t r);
		longint o [3], d [3], a [3], ab [3], ac [3], n [3], ao [3], p [3], ap [3];
		longint num, den, d00, d01, d11, d02, d12;
		longint unsigned tq;
		logic signed [127:0] w00, w01, w11, w02, w12, det, un, vn;
		isect_t res;
		res = '0;
		for (int k = 0; k < 3; k++) begin
			o[k] = r.org[k];
			d[k] = r.dir[k];
			a[k] = coord(tri_regs[REG_VERTEX_A], k);
			ab[k] = coord(tri_regs[REG_VERTEX_B], k) - a[k];
			ac[k] = coord(tri_regs[REG_VERTEX_C], k) - a[k];
			n[k] = coord(tri_regs[REG_UNIT_NORMAL], k);
			ao[k] = a[k] - o[k];
		end
		num = dot3(ao, n);
		den = dot3(d, n);
		if (den == 0) return res;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		if (num < 0) return res;
		tq = (longint'(num) << DIST_FRAC) / den;
		if (tq > 64'hFFFF_FFFF) return res;
		for (int k = 0; k < 3; k++) begin
			// round to nearest, halves up: floor of (x + half) / 2^16
			p[k] = o[k] + ((longint'(tq) * d[k] + (64'sd1 <<< (DIST_FRAC-1))) >>> DIST_FRAC);
			if (p[k] < -(64'sd1 <<< (CW-1)) || p[k] > (64'sd1 <<< (CW-1)) - 1) return res;
			ap[k] = p[k] - a[k];
		end
		d00 = dot3(ab, ab); d01 = dot3(ab, ac); d11 = dot3(ac, ac);
		d02 = dot3(ab, ap); d12 = dot3(ac, ap);
		w00 = d00; w01 = d01; w11 = d11; w02 = d02; w12 = d12;
		det = w00*w11 - w01*w01;
		if (det <= 0) return res;
		un = w11*w02 - w01*w12;
		vn = w00*w12 - w01*w02;
		if (un < 0 || vn < 0 || un + vn > det) return res;
		res.hit = 1'b1;
		res.distance = tq[DIST_W-1:0];
		res.px = CW'(p[0]); res.py = CW'(p[1]); res.pz = CW'(p[2]);
		res.nx = CW'(n[0]); res.ny = CW'(n[1]); res.nz = CW'(n[2]);
		return res;
	endfunction

	// apb write: setup cycle then access cycle
	task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= APB_AW'(8 * int'(idx)); pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		tri_regs[idx] = value[REG_W-1:0];
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	function automatic logic [APB_DW-1:0] pack3(longint x, longint y, longint z);
		logic [APB_DW-1:0] v;
		v = '0;
		v[CW-1:0] = x[CW-1:0];
		v[2*CW-1:CW] = y[CW-1:0];
		v[3*CW-1:2*CW] = z[CW-1:0];
		v[APB_DW-1] = 1'($urandom_range(0, 1));  // ignored bit
		return v;
	endfunction

	// software side: normalized (c-a)x(b-a) in Q10.10
	task automatic load_triangle(longint a [3], longint b [3], longint c [3]);
		real e1 [3], e2 [3], cr [3], len;
		longint nq [3];
		for (int k = 0; k < 3; k++) begin
			e1[k] = c[k] - a[k];
			e2[k] = b[k] - a[k];
		end
		cr[0] = e1[1]*e2[2] - e1[2]*e2[1];
		cr[1] = e1[2]*e2[0] - e1[0]*e2[2];
		cr[2] = e1[0]*e2[1] - e1[1]*e2[0];
		len = $sqrt(cr[0]*cr[0] + cr[1]*cr[1] + cr[2]*cr[2]);
		for (int k = 0; k < 3; k++)
			nq[k] = (len == 0.0) ? 0 : longint'(cr[k] / len * 1024.0);
		write_reg(REG_VERTEX_A, pack3(a[0], a[1], a[2]));
		write_reg(REG_VERTEX_B, pack3(b[0], b[1], b[2]));
		write_reg(REG_VERTEX_C, pack3(c[0], c[1], c[2]));
		write_reg(REG_UNIT_NORMAL, pack3(nq[0], nq[1], nq[2]));
	endtask

	task automatic send_ray(ray_t r, bit known, isect_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				ray_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		ray_ch.valid <= 1'b1;
		ray_ch.origin_x <= r.org[0]; ray_ch.origin_y <= r.org[1]; ray_ch.origin_z <= r.org[2];
		ray_ch.dir_x <= r.dir[0]; ray_ch.dir_y <= r.dir[1]; ray_ch.dir_z <= r.dir[2];
		@(posedge clk);
		while (!ray_ch.ready) @(posedge clk);
		pending_hits.push_back(known ? want : intersect_ray(r));
		burst_left--;
		@(negedge clk);
	endtask

	task automatic settle();
		ray_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_hits.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	function automatic ray_t random_ray(longint a [3], longint b [3], longint c [3]);
		ray_t r;
		real u, v, tgt;
		longint scale;
		if ($urandom_range(0, 3) == 0) begin
			for (int k = 0; k < 3; k++) begin
				r.org[k] = CW'($urandom());
				r.dir[k] = CW'($urandom());
			end
			return r;
		end
		// aim through a point near the triangle so most rays reach the barycentric test
		u = $urandom_range(0, 1100) / 1000.0;
		v = $urandom_range(0, 1100) / 1000.0;
		if (u + v > 1.15) begin
			u = 1.0 - u / 2.0;
			v = v / 4.0;
		end
		scale = $urandom_range(1, 8);
		for (int k = 0; k < 3; k++) begin
			tgt = a[k] + u * (b[k] - a[k]) + v * (c[k] - a[k]);
			r.org[k] = CW'($urandom_range(0, 400000) - 200000);
			r.dir[k] = CW'(longint'((tgt - r.org[k]) / scale));
		end
		return r;
	endfunction

	// result side: stall pattern, chosen anew whenever its run ends
	int ready_mode = 0, ready_left = 0;
	logic [7:0] ready_mask = 8'hff;
	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 2);
			ready_left = $urandom_range(32, 300);
			ready_mask = 8'($urandom());
		end
		ready_left--;
		ready_mask = {ready_mask[6:0], ready_mask[7]};
		case (ready_mode)
			0: isect_ch.ready <= 1'b1;
			1: isect_ch.ready <= ($urandom_range(0, 9) < 6);
			default: isect_ch.ready <= ready_mask[0];
		endcase
	end

	always @(posedge clk) begin
		isect_t got, want;
		if (isect_ch.valid && isect_ch.ready) begin
			got = '{isect_ch.hit, isect_ch.distance, isect_ch.point_x, isect_ch.point_y,
				isect_ch.point_z, isect_ch.norm_x, isect_ch.norm_y, isect_ch.norm_z};
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transfer: %p", got);
			end else begin
				want = pending_hits.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		row_t rows [$];
		longint a [3], b [3], c [3];
		longint span;
		ray_t r;
		isect_t miss;
		miss = '0;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// registers still at reset: zero normal, every ray is a parallel miss
		rows.push_back('{'{'{21'sh0FFFFF, 21'sh0FFFFF, 21'sh0FFFFF}, '{21'sh100000, 21'sh100000, 21'sh100000}}, 1'b1, miss});
		rows.push_back('{'{'{21'sh100000, 21'sh100000, 21'sh100000}, '{21'sh0FFFFF, 21'sh0FFFFF, 21'sh0FFFFF}}, 1'b1, miss});
		rows.push_back('{'{'{21'sd0, 21'sd0, 21'sd0}, '{21'sd0, 21'sd0, 21'sd0}}, 1'b1, miss});
		foreach (rows[i]) send_ray(rows[i].ray, rows[i].known, rows[i].want);
		settle();

		// right triangle in the z=0 plane, four units on a side
		a = '{0, 0, 0}; b = '{4096, 0, 0}; c = '{0, 4096, 0};
		load_triangle(a, b, c);
		rows.delete();
		rows.push_back('{'{'{1024, 1024, 4096}, '{0, 0, -1024}}, 1'b0, miss});          // plain hit
		rows.push_back('{'{'{1024, 1024, 0}, '{0, 0, 1024}}, 1'b0, miss});              // origin on triangle
		rows.push_back('{'{'{1024, 1024, 4096}, '{0, 0, 1024}}, 1'b0, miss});           // behind origin
		rows.push_back('{'{'{1024, 1024, 4096}, '{1024, 0, 0}}, 1'b0, miss});           // parallel
		rows.push_back('{'{'{8192, 8192, 1024}, '{0, 0, -1024}}, 1'b0, miss});          // outside edges
		rows.push_back('{'{'{4096, 0, 512}, '{0, 0, -1024}}, 1'b0, miss});              // on a vertex
		rows.push_back('{'{'{2048, 2048, 512}, '{0, 0, -1024}}, 1'b0, miss});           // on hypotenuse
		rows.push_back('{'{'{1024, 1024, 21'sh0FFFFF}, '{0, 0, -1}}, 1'b0, miss});      // t too large
		rows.push_back('{'{'{1024, 1024, 1}, '{0, 0, -1}}, 1'b0, miss});
		rows.push_back('{'{'{21'sh0FFFFF, 21'sh0FFFFF, 21'sh0FFFFF}, '{21'sh100000, 21'sh100000, 21'sh100000}}, 1'b0, miss});
		rows.push_back('{'{'{21'sh100000, 21'sh100000, 21'sh100000}, '{21'sh0FFFFF, 21'sh0FFFFF, 21'sh0FFFFF}}, 1'b0, miss});
		rows.push_back('{'{'{21'sh0FFFFF, 0, 1024}, '{21'sh100000, 0, -1024}}, 1'b0, miss}); // point just outside an edge
		rows.push_back('{'{'{1024, 1024, 2048}, '{0, 0, 0}}, 1'b0, miss});
		foreach (rows[i]) send_ray(rows[i].ray, rows[i].known, rows[i].want);
		settle();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				2: begin  // collinear vertices
					a = '{0, 0, 0}; b = '{2048, 2048, 0}; c = '{4096, 4096, 0};
					load_triangle(a, b, c);
					write_reg(REG_UNIT_NORMAL, pack3(0, 0, 1024));
				end
				3: begin  // fields at their limits
					a = '{1048575, 1048575, -1048576}; b = '{-1048576, 1048575, 0};
					c = '{1048575, -1048576, 1048575};
					load_triangle(a, b, c);
				end
				4: begin  // every register bit set
					write_reg(REG_VERTEX_A, '1);
					write_reg(REG_VERTEX_B, '1);
					write_reg(REG_VERTEX_C, '1);
					write_reg(REG_UNIT_NORMAL, '1);
					a = '{-1, -1, -1}; b = a; c = a;
				end
				5: begin  // normal that does not match the triangle
					a = '{0, 0, 0}; b = '{8192, 0, 0}; c = '{0, 8192, 1024};
					load_triangle(a, b, c);
					write_reg(REG_UNIT_NORMAL, pack3(300, -200, 900));
				end
				default: begin
					span = (ph % 2) ? 16384 : 300000;
					for (int k = 0; k < 3; k++) begin
						a[k] = $urandom_range(0, 2*span) - span;
						b[k] = $urandom_range(0, 2*span) - span;
						c[k] = $urandom_range(0, 2*span) - span;
					end
					load_triangle(a, b, c);
				end
			endcase
			for (int i = 0; i < RAYS_PER_PHASE; i++) begin
				r = random_ray(a, b, c);
				send_ray(r, 1'b0, miss);
			end
			settle();
		end

		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* files.f */
src/rti_pkg.sv
src/rti_ray_if.sv
src/rti_isect_if.sv
src/ray_triangle_intersect.sv
tb/sv/tb_ray_triangle_intersect.sv
